### sv/mse_pkg.sv
// Shared types, op codes and sizing constants for the execute core.
// No dependencies; used by mse_front, mse_back, the top level and the testbench.
`timescale 1ns / 1ps

package mse_pkg;

    localparam int DATA_MEM_BYTES = 4096;
    localparam int MEM_WORDS      = DATA_MEM_BYTES / 4;
    localparam int WADDR_W        = $clog2(MEM_WORDS);
    localparam int FIFO_DEPTH     = 2;
    localparam int LINK_REG       = 31;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_ADDI = 4'd1,
        OP_SUB  = 4'd2,
        OP_MULT = 4'd3,
        OP_AND  = 4'd4,
        OP_OR   = 4'd5,
        OP_SLL  = 4'd6,
        OP_SLT  = 4'd7,
        OP_SLTI = 4'd8,
        OP_LUI  = 4'd9,
        OP_LW   = 4'd10,
        OP_SW   = 4'd11,
        OP_LI   = 4'd12,
        OP_LA   = 4'd13,
        OP_J    = 4'd14,
        OP_JAL  = 4'd15
    } t_op;

    // Decoded instruction carried from the front part to the back part.
    typedef struct packed {
        t_op         op;
        logic [4:0]  rd;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic [15:0] off;
        logic [4:0]  sh;
        logic [15:0] target;
    } t_instr;

    typedef struct packed {
        logic        wr;
        logic [4:0]  wreg;
        logic [31:0] wval;
        logic [15:0] npc;
        logic        fault;
        logic [31:0] eaddr;
    } t_result;

endpackage

### sv/mse_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### sv/mse_front.sv
// Front part: accept instructions from the input stream into a short queue.
// Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mse_pkg::t_instr  i_instr,
    output logic             o_valid,
    input  logic             i_ready,
    output mse_pkg::t_instr  o_instr
);
    mse_pkg::t_instr r_q [mse_pkg::FIFO_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'(mse_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_instr = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_instr;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

### sv/mse_back.sv
// Back part: register file, data memory, pc; execute into a stage 1 register
// followed by an output register. Depends on mse_pkg and mse_ram.
`timescale 1ns / 1ps

module mse_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mse_pkg::t_instr  i_instr,
    output logic             o_valid,
    input  logic             i_ready,
    output mse_pkg::t_result o_res
);
    localparam int AW = mse_pkg::WADDR_W;

    logic [31:0] r_rf [32];
    logic [15:0] r_pc;

    // clearing pass over the data memory after reset
    logic             r_clr;
    logic [AW-1:0]    r_clr_addr;

    // stage 1 registers (operands read, memory addressed)
    logic             r_v1;
    mse_pkg::t_result r_res1;
    logic             r_load1;
    logic [31:0]      r_prod;
    logic             r_ismul;
    // output register
    logic             r_v2;
    mse_pkg::t_result r_res2;

    logic adv2, adv1;
    assign adv2    = !r_v2 || i_ready;
    assign adv1    = (!r_v1 || adv2) && !r_clr;
    assign o_ready = adv1;

    logic [31:0]      rdata;
    logic [31:0]      s1_stall_rdata_hold;
    logic             r_held;
    logic [31:0]      ld_val;
    logic [31:0]      s1_val;
    mse_pkg::t_result s1_res;

    // final value of stage 1, used for forwarding, retirement and output
    always_comb begin
        s1_val = r_res1.wval;
        if (r_load1) s1_val = ld_val;
        if (r_ismul) s1_val = r_prod;
        s1_res      = r_res1;
        s1_res.wval = s1_val;
    end

    function automatic logic [31:0] rd_reg(input logic [4:0] idx, input logic [31:0] rf,
                                           input logic hit, input logic [31:0] fwd);
        if (idx == 5'd0) return 32'd0;
        if (hit) return fwd;
        return rf;
    endfunction

    mse_pkg::t_instr in;
    logic [31:0] a, b, imm, ea, sum, dif;
    logic ok, take;
    mse_pkg::t_result n_res;
    logic n_load, n_mul;
    assign in   = i_instr;
    assign take = i_valid && adv1;
    assign a = rd_reg(in.rs, r_rf[in.rs], r_v1 && r_res1.wr && r_res1.wreg == in.rs, s1_val);
    assign b = rd_reg(in.rt, r_rf[in.rt], r_v1 && r_res1.wr && r_res1.wreg == in.rt, s1_val);
    assign imm = {{16{in.imm[15]}}, in.imm};
    assign ea  = a + {16'd0, in.off};
    assign ok  = (ea[1:0] == 2'b00) &&
                 ({1'b0, ea} + 33'd3 < 33'(mse_pkg::DATA_MEM_BYTES));
    assign sum = a + b;
    assign dif = a - b;

    always_comb begin
        n_res       = '0;
        n_res.npc   = r_pc + 16'd1;
        n_load      = 1'b0;
        n_mul       = 1'b0;
        case (in.op)
            mse_pkg::OP_ADD:  begin n_res.wr = 1'b1; n_res.wreg = in.rd; n_res.wval = sum; end
            mse_pkg::OP_ADDI: begin n_res.wr = 1'b1; n_res.wreg = in.rt; n_res.wval = a + imm; end
            mse_pkg::OP_SUB:  begin n_res.wr = 1'b1; n_res.wreg = in.rd; n_res.wval = dif; end
            mse_pkg::OP_MULT: begin n_res.wr = 1'b1; n_res.wreg = in.rd; n_mul = 1'b1; end
            mse_pkg::OP_AND:  begin n_res.wr = 1'b1; n_res.wreg = in.rd; n_res.wval = a & b; end
            mse_pkg::OP_OR:   begin n_res.wr = 1'b1; n_res.wreg = in.rd; n_res.wval = a | b; end
            mse_pkg::OP_SLL:  begin n_res.wr = 1'b1; n_res.wreg = in.rd; n_res.wval = a << in.sh; end
            mse_pkg::OP_SLT:  begin
                n_res.wr = 1'b1; n_res.wreg = in.rd;
                n_res.wval = {31'd0, $signed(a) < $signed(b)};
            end
            mse_pkg::OP_SLTI: begin
                n_res.wr = 1'b1; n_res.wreg = in.rt;
                n_res.wval = {31'd0, $signed(a) < $signed(imm)};
            end
            mse_pkg::OP_LUI:  begin n_res.wr = 1'b1; n_res.wreg = in.rt; n_res.wval = {in.imm, 16'd0}; end
            mse_pkg::OP_LW:   begin
                n_res.eaddr = ea; n_res.fault = !ok;
                n_res.wr = ok; n_res.wreg = in.rt; n_load = ok;
            end
            mse_pkg::OP_SW:   begin n_res.eaddr = ea; n_res.fault = !ok; end
            mse_pkg::OP_LI:   begin n_res.wr = 1'b1; n_res.wreg = in.rt; n_res.wval = imm; end
            mse_pkg::OP_LA:   begin n_res.wr = 1'b1; n_res.wreg = in.rt; n_res.wval = {16'd0, in.target}; end
            mse_pkg::OP_J:    n_res.npc = in.target;
            mse_pkg::OP_JAL:  begin
                n_res.wr = 1'b1; n_res.wreg = 5'(mse_pkg::LINK_REG);
                n_res.wval = {13'd0, {1'b0, r_pc} + 17'd1, 2'b00}; n_res.npc = in.target;
            end
            default: ;
        endcase
        if (n_res.wreg == 5'd0) begin
            n_res.wr = 1'b0;
        end
        if (!n_res.wr) begin
            n_res.wreg = 5'd0; n_res.wval = 32'd0; n_load = 1'b0; n_mul = 1'b0;
        end
    end

    // data memory, one big-endian word per entry; read data aligns with stage 1
    logic          we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata;
    assign we        = r_clr || (take && in.op == mse_pkg::OP_SW && ok);
    assign ram_addr  = r_clr ? r_clr_addr : ea[AW+1:2];
    assign ram_wdata = r_clr ? 32'd0 : b;
    mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::MEM_WORDS)) u_dmem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(rdata)
    );

    // hold load data while stage 1 stalls (RAM output changes each cycle)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else begin
            r_held <= r_v1 && !adv2;
        end
        if (r_v1 && !adv2 && !r_held) s1_stall_rdata_hold <= rdata;
    end
    assign ld_val = r_held ? s1_stall_rdata_hold : rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_pc       <= 16'd0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            for (int k = 0; k < 32; k++) r_rf[k] <= 32'd0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + {{(AW-1){1'b0}}, 1'b1};
                if (r_clr_addr == '1) r_clr <= 1'b0;
            end
            if (adv2) r_v2 <= r_v1;
            if (adv1) r_v1 <= take;
            if (take) r_pc <= n_res.npc;
            // retire stage 1 into the register file
            if (r_v1 && adv2 && r_res1.wr) r_rf[r_res1.wreg] <= s1_val;
        end
        if (take) begin
            r_res1  <= n_res;
            r_load1 <= n_load;
            r_ismul <= n_mul;
            r_prod  <= a * b;
        end
        if (r_v1 && adv2) begin
            r_res2 <= s1_res;
        end
    end

    assign o_valid = r_v2;
    assign o_res   = r_res2;
endmodule

### sv/mips_subset_execute_core.sv
// Top level of the execute core: front queue and execute back end.
// Depends on mse_pkg, mse_front, mse_back.
`timescale 1ns / 1ps

// One decoded instruction enters per transaction and one result transaction
// leaves for each, in order. Sustained rate is one instruction per cycle while
// the result side accepts; each result passes through the queue, the stage 1
// register and the output register before it is offered. Register values are
// forwarded from the execute stage to a dependent instruction, so dependences
// cause no stall. The data memory holds 32-bit big-endian words. After reset
// the register file reads as zero and the back end clears the data memory, one
// word per cycle, holding off instructions until every word is cleared.
module mips_subset_execute_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[3:0], dest_reg[8:4], src_reg[13:9], second_reg[18:14], immediate[34:19],
    // mem_offset[50:35], shift_amount[55:51], jump_target[71:56]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // reg_write[0], written_reg[5:1], written_value[37:6], next_pc[53:38],
    // mem_fault[54], fault_address[86:55], zero fill
    output logic [87:0] m_axis_tdata
);
    mse_pkg::t_instr in_i, q_i;
    mse_pkg::t_result res;
    logic q_v, q_r;

    // unpack the transaction
    always_comb begin
        in_i.op     = mse_pkg::t_op'(s_axis_tdata[3:0]);
        in_i.rd     = s_axis_tdata[8:4];
        in_i.rs     = s_axis_tdata[13:9];
        in_i.rt     = s_axis_tdata[18:14];
        in_i.imm    = s_axis_tdata[34:19];
        in_i.off    = s_axis_tdata[50:35];
        in_i.sh     = s_axis_tdata[55:51];
        in_i.target = s_axis_tdata[71:56];
    end

    mse_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_instr(in_i),
        .o_valid(q_v), .i_ready(q_r), .o_instr(q_i)
    );

    mse_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_v), .o_ready(q_r), .i_instr(q_i),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {1'b0, res.eaddr, res.fault, res.npc, res.wval, res.wreg, res.wr};
endmodule

### sv/mse_checker.sv
// Port-level checker for the execute core, bound to the top level.
// Depends on mips_subset_execute_core ports only.
`timescale 1ns / 1ps

module mse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("hold");
    a_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[5:1] != 5'd0) else $error("r0");
    a_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[37:1] == 37'd0) else $error("nowr");
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[54] |-> !m_axis_tdata[0]) else $error("fault");
endmodule

bind mips_subset_execute_core mse_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

### tb/testbench.sv
// Self-checking testbench for the execute core: directed table, then random programs.
// Depends on mse_pkg and mips_subset_execute_core.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        mse_pkg::t_op op;
        logic [4:0]  rd;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic [15:0] off;
        logic [4:0]  sh;
        logic [15:0] target;
        logic        known;     // expected result typed in below
        logic [87:0] result;
    } t_row;

    localparam int LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;

    mips_subset_execute_core i_dut (.*);

    // Predictor state.
    logic [31:0] regs [32];
    logic [7:0]  dmem [mse_pkg::DATA_MEM_BYTES];
    logic [15:0] pc;

    logic [87:0] pending_results [$];
    int          errors;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off;
    bit          sending_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [71:0] pack_instr(t_row r);
        return {r.target, r.sh, r.off, r.imm, r.rt, r.rs, r.rd, r.op};
    endfunction

    function automatic logic [87:0] pack_result(logic wr, logic [4:0] wreg, logic [31:0] wval,
                                                logic [15:0] npc, logic fault,
                                                logic [31:0] eaddr);
        return {1'b0, eaddr, fault, npc, wval, wreg, wr};
    endfunction

    // Execute one instruction against the predictor state, return packed result.
    function automatic logic [87:0] execute_instr(t_row r);
        logic [31:0] a, b, imm32, wval, eaddr;
        logic [4:0]  wreg;
        logic        wr, fault;
        logic [15:0] npc;
        a = regs[r.rs];
        b = regs[r.rt];
        imm32 = {{16{r.imm[15]}}, r.imm};
        wr = 1'b1; wreg = r.rt; wval = '0; fault = 1'b0; eaddr = '0;
        npc = pc + 16'd1;
        case (r.op)
            mse_pkg::OP_ADD:  begin wreg = r.rd; wval = a + b; end
            mse_pkg::OP_ADDI: wval = a + imm32;
            mse_pkg::OP_SUB:  begin wreg = r.rd; wval = a - b; end
            mse_pkg::OP_MULT: begin wreg = r.rd; wval = a * b; end
            mse_pkg::OP_AND:  begin wreg = r.rd; wval = a & b; end
            mse_pkg::OP_OR:   begin wreg = r.rd; wval = a | b; end
            mse_pkg::OP_SLL:  begin wreg = r.rd; wval = a << r.sh; end
            mse_pkg::OP_SLT:  begin wreg = r.rd; wval = {31'd0, $signed(a) < $signed(b)}; end
            mse_pkg::OP_SLTI: wval = {31'd0, $signed(a) < $signed(imm32)};
            mse_pkg::OP_LUI:  wval = {r.imm, 16'd0};
            mse_pkg::OP_LW, mse_pkg::OP_SW: begin
                eaddr = a + {16'd0, r.off};
                fault = (eaddr[1:0] != 2'd0) ||
                        ({32'd0, eaddr} + 64'd3 >= 64'(mse_pkg::DATA_MEM_BYTES));
                wr = 1'b0;
                if (!fault && r.op == mse_pkg::OP_LW) begin
                    wr = 1'b1;
                    wval = {dmem[eaddr], dmem[eaddr + 1], dmem[eaddr + 2], dmem[eaddr + 3]};
                end else if (!fault) begin
                    {dmem[eaddr], dmem[eaddr + 1], dmem[eaddr + 2], dmem[eaddr + 3]} = b;
                end
            end
            mse_pkg::OP_LI:   wval = imm32;
            mse_pkg::OP_LA:   wval = {16'd0, r.target};
            mse_pkg::OP_J:    begin wr = 1'b0; npc = r.target; end
            default: begin
                wreg = 5'd31;
                wval = ({16'd0, pc} + 32'd1) * 32'd4;
                npc = r.target;
            end
        endcase
        if (wr && wreg == 5'd0) wr = 1'b0;
        if (wr) begin
            regs[wreg] = wval;
        end else begin
            wreg = '0;
            wval = '0;
        end
        pc = npc;
        return pack_result(wr, wreg, wval, npc, fault, eaddr);
    endfunction

    task automatic report_mismatch(string what, logic [87:0] got, logic [87:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // Offer one instruction; hold until accepted.
    task automatic send_instr(t_row r);
        logic [87:0] predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= pack_instr(r);
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = execute_instr(r);
        if (r.known && predicted != r.result)
            report_mismatch("table", predicted, r.result);
        pending_results.push_back(r.known ? r.result : predicted);
        @(negedge i_clk);
    endtask

    function automatic t_row make_row(mse_pkg::t_op op, int rd, int rs, int rt, int imm,
                                      int off, int sh, int tgt);
        t_row r;
        r.op = op; r.rd = 5'(rd); r.rs = 5'(rs); r.rt = 5'(rt); r.imm = 16'(imm);
        r.off = 16'(off); r.sh = 5'(sh); r.target = 16'(tgt); r.known = 1'b0; r.result = '0;
        return r;
    endfunction

    // Random instruction; mostly small registers and aligned in-range addresses
    // so that loads and stores really reach memory.
    function automatic t_row random_row();
        t_row r;
        int   w;
        r = make_row(mse_pkg::t_op'(4'($urandom_range(15))), $urandom_range(31),
                     $urandom_range(31), $urandom_range(31), $urandom, $urandom,
                     $urandom_range(31), $urandom);
        w = $urandom_range(99);
        if (w < 60) begin
            r.rd = 5'($urandom_range(7));
            r.rs = 5'($urandom_range(7));
            r.rt = 5'($urandom_range(7));
        end
        if ((r.op == mse_pkg::OP_LW || r.op == mse_pkg::OP_SW) && w < 70) begin
            r.rs = 5'd0;
            r.off = {14'($urandom_range(63)), 2'b00};
        end
        return r;
    endfunction

    // Result side: random stalls, one long hold-off, compare against queue.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [87:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected", m_axis_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want[0])
                    report_mismatch("reg_write", m_axis_tdata, want);
                if (m_axis_tdata[5:1] !== want[5:1])
                    report_mismatch("written_reg", m_axis_tdata, want);
                if (m_axis_tdata[37:6] !== want[37:6])
                    report_mismatch("written_value", m_axis_tdata, want);
                if (m_axis_tdata[53:38] !== want[53:38])
                    report_mismatch("next_pc", m_axis_tdata, want);
                if (m_axis_tdata[54] !== want[54])
                    report_mismatch("mem_fault", m_axis_tdata, want);
                if (m_axis_tdata[86:55] !== want[86:55])
                    report_mismatch("fault_address", m_axis_tdata, want);
            end
        end
    end

    initial begin
        t_row table_rows [$];
        t_row r;
        int   drain;
        errors = 0; cycles = 0; hold_off = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        foreach (regs[k]) regs[k] = '0;
        foreach (dmem[k]) dmem[k] = '0;
        pc = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: extremes, every op, register zero, faults, link.
        r = make_row(mse_pkg::OP_ADD, 1, 0, 0, 0, 0, 0, 0); r.known = 1'b1;
        r.result = pack_result(1'b1, 5'd1, 32'd0, 16'd1, 1'b0, 32'd0); table_rows.push_back(r);
        table_rows.push_back(make_row(mse_pkg::OP_LI, 0, 0, 1, -32768, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_LI, 0, 0, 2, 32767, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_LUI, 0, 0, 3, 16'hFFFF, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_LI, 0, 0, 0, 5, 0, 0, 0)); // write to zero dropped
        table_rows.push_back(make_row(mse_pkg::OP_ADD, 4, 1, 3, 0, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_ADDI, 0, 3, 5, -1, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_SUB, 6, 1, 2, 0, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_MULT, 7, 3, 3, 0, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_AND, 8, 3, 2, 0, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_OR, 9, 1, 2, 0, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_SLL, 10, 2, 0, 0, 0, 31, 0));
        table_rows.push_back(make_row(mse_pkg::OP_SLT, 11, 1, 2, 0, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_SLTI, 0, 2, 12, -32768, 0, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_LA, 0, 0, 13, 0, 0, 0, 16'hFFFF));
        table_rows.push_back(make_row(mse_pkg::OP_SW, 0, 0, 3, 0, 4092, 0, 0));
        table_rows.push_back(make_row(mse_pkg::OP_LW, 0, 0, 14, 0, 4092, 0, 0));
        r = make_row(mse_pkg::OP_LW, 0, 0, 14, 0, 4093, 0, 0); r.known = 1'b1; // misaligned
        r.result = pack_result(1'b0, 5'd0, 32'd0, 16'd18, 1'b1, 32'd4093);
        table_rows.push_back(r);
        r = make_row(mse_pkg::OP_SW, 0, 0, 3, 0, 4096, 0, 0); r.known = 1'b1;  // out of range
        r.result = pack_result(1'b0, 5'd0, 32'd0, 16'd19, 1'b1, 32'd4096);
        table_rows.push_back(r);
        table_rows.push_back(make_row(mse_pkg::OP_LW, 0, 13, 15, 0, 16'hFFFF, 0, 0)); // out of range, no wrap
        r = make_row(mse_pkg::OP_J, 0, 0, 0, 0, 0, 0, 16'hFFFF); r.known = 1'b1;
        r.result = pack_result(1'b0, 5'd0, 32'd0, 16'hFFFF, 1'b0, 32'd0); table_rows.push_back(r);
        r = make_row(mse_pkg::OP_JAL, 0, 0, 0, 0, 0, 0, 0); r.known = 1'b1; // pc wraps, link does not
        r.result = pack_result(1'b1, 5'd31, 32'h0004_0000, 16'd0, 1'b0, 32'd0);
        table_rows.push_back(r);
        table_rows.push_back(make_row(mse_pkg::OP_JAL, 0, 0, 0, 0, 0, 0, 100));
        foreach (table_rows[k]) send_instr(table_rows[k]);

        // Random programs in three idling phases, long hold-off in the first.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 53 : 0;
            recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 29 : 0;
            if (phase == 0) hold_off = 200;
            for (int n = 0; n < 380; n++) send_instr(random_row());
        end
        s_axis_tvalid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 10000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
